[src/hcsp_pkg.sv]
// Shared types and constants for the HTTP chunk size line parser
package hcsp_pkg;

    localparam int SIZE_BITS   = 64;
    localparam int BLANK_LIMIT = 10;
    localparam int ACC_W       = SIZE_BITS - 1;
    localparam int BUDGET_W    = $clog2(SIZE_BITS + 1);
    localparam int BLANK_W     = 4;
    localparam int COUNT_W     = 17;
    localparam int LIMIT_W     = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [CFG_IDX_W-1:0] REG_STRICT_CRLF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 2'd1;

    typedef enum logic [1:0] {
        CMD_PARSE     = 2'd0,
        CMD_DATA_DONE = 2'd1,
        CMD_RESTART   = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_SPACE   = 2'd2,
        ST_GENERAL = 2'd3
    } status_t;

    // classified input byte
    typedef struct packed {
        cmd_t       command;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_zero;
        logic       is_lf;
        logic       is_cr;
        logic       is_semi;
        logic       is_blank;
        logic       is_bad_ctrl;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic             line_done;
        logic             data_follows;
        logic [ACC_W-1:0] chunk_size;
    } result_t;

endpackage

[src/hcsp_front.sv]
// Front end: accepts stream bytes, classifies them and queues them for the parser
module hcsp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    command,
    input  logic [7:0]    data_byte,
    output logic          item_valid,
    output hcsp_pkg::item_t item,
    input  logic          item_take
);
    import hcsp_pkg::*;

    item_t      cls;
    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        cls             = '0;
        cls.command     = cmd_t'(command);
        cls.is_zero     = (data_byte == CH_ZERO);
        cls.is_lf       = (data_byte == CH_LF);
        cls.is_cr       = (data_byte == CH_CR);
        cls.is_semi     = (data_byte == CH_SEMI);
        cls.is_blank    = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
        cls.is_bad_ctrl = (data_byte != CH_TAB) &&
                          ((data_byte < CH_SPACE) || (data_byte == CH_DEL));
        if ((data_byte >= 8'h30) && (data_byte <= 8'h39))
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = data_byte[3:0];
        end
        else if (((data_byte >= 8'h41) && (data_byte <= 8'h46)) ||
                 ((data_byte >= 8'h61) && (data_byte <= 8'h66)))
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(data_byte[2:0] + 3'd1) + 4'd8;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("front queue count out of range");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> item_valid)
        else $error("transfer into front queue lost");

endmodule

[src/hcsp_back.sv]
// Back end: size line state machine, configuration registers and result queue
module hcsp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  hcsp_pkg::item_t                   item,
    output logic                              item_take,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcsp_pkg::LIMIT_W-1:0]      cfg_data,
    output logic                              empty,
    input  logic                              pop,
    output hcsp_pkg::result_t                 result
);
    import hcsp_pkg::*;

    typedef enum logic [11:0] {
        PH_END         = 12'b0000_0000_0001,
        PH_END_LF      = 12'b0000_0000_0010,
        PH_START       = 12'b0000_0000_0100,
        PH_PART        = 12'b0000_0000_1000,
        PH_CR          = 12'b0000_0001_0000,
        PH_EXT         = 12'b0000_0010_0000,
        PH_LF          = 12'b0000_0100_0000,
        PH_DATA        = 12'b0000_1000_0000,
        PH_TRAILER     = 12'b0001_0000_0000,
        PH_ERR_SYNTAX  = 12'b0010_0000_0000,
        PH_ERR_SPACE   = 12'b0100_0000_0000,
        PH_ERR_GENERAL = 12'b1000_0000_0000
    } phase_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic                strict_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [ACC_W-1:0]    accum_reg;
    logic [ACC_W-1:0]    accum_next;
    logic [BUDGET_W-1:0] budget_reg;
    logic [BUDGET_W-1:0] budget_next;
    logic [BLANK_W-1:0]  blank_reg;
    logic [BLANK_W-1:0]  blank_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    phase_t              eph;
    logic [ACC_W-1:0]    accum_base;
    logic [BUDGET_W-1:0] budget_base;
    logic [BLANK_W-1:0]  blank_base;
    logic [COUNT_W-1:0]  count_base;
    logic [COUNT_W-1:0]  count_inc;
    logic                failed;
    status_t             fail_code;
    status_t             status;
    logic                done;
    result_t             res;

    result_t             omem [2];
    logic                owr_ptr_reg;
    logic                ord_ptr_reg;
    logic [1:0]          ocount_reg;
    logic [1:0]          ocount_next;
    logic                out_rd;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b1;
            limit_reg  <= LIMIT_W'(8190);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STRICT_CRLF: strict_reg <= cfg_data[0];
                REG_LINE_LIMIT:  limit_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // parser
    assign out_rd    = pop && !empty;
    assign item_take = item_valid && ((ocount_reg != 2'd2) || out_rd);

    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        budget_next = budget_reg;
        blank_next  = blank_reg;
        count_next  = count_reg;
        status      = ST_OK;
        done        = 1'b0;
        failed      = 1'b0;
        fail_code   = ST_OK;

        eph         = phase_reg;
        accum_base  = accum_reg;
        budget_base = budget_reg;
        blank_base  = blank_reg;
        count_base  = count_reg;
        if (phase_reg == PH_START)
        begin
            eph         = PH_PART;
            accum_base  = '0;
            budget_base = BUDGET_W'(SIZE_BITS);
            blank_base  = '0;
            count_base  = '0;
        end
        count_inc = (count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;

        if (item.command == CMD_RESTART)
        begin
            phase_next  = PH_START;
            accum_next  = '0;
            budget_next = BUDGET_W'(SIZE_BITS);
            blank_next  = '0;
            count_next  = '0;
        end
        else if (phase_reg == PH_ERR_SYNTAX)
        begin
            status = ST_SYNTAX;
        end
        else if (phase_reg == PH_ERR_SPACE)
        begin
            status = ST_SPACE;
        end
        else if (phase_reg == PH_ERR_GENERAL)
        begin
            status = ST_GENERAL;
        end
        else if (item.command == CMD_DATA_DONE)
        begin
            phase_next = PH_END;
        end
        else if (item.command == CMD_PARSE)
        begin
            if ((phase_reg == PH_END) || (phase_reg == PH_END_LF))
            begin
                if (item.is_lf)
                begin
                    if (strict_reg && (phase_reg != PH_END_LF))
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                else if (item.is_cr && (phase_reg == PH_END))
                begin
                    phase_next = PH_END_LF;
                end
                else
                begin
                    failed    = 1'b1;
                    fail_code = ST_SYNTAX;
                end
            end
            else if ((phase_reg == PH_START) && !item.is_hex)
            begin
                failed    = 1'b1;
                fail_code = ST_SYNTAX;
            end
            else if ((eph == PH_DATA) || (eph == PH_TRAILER))
            begin
                failed    = 1'b1;
                fail_code = ST_GENERAL;
            end
            else
            begin
                phase_next  = eph;
                accum_next  = accum_base;
                budget_next = budget_base;
                blank_next  = blank_base;
                count_next  = count_inc;
                if (item.is_lf)
                begin
                    if (strict_reg && (eph != PH_LF))
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                    else
                    begin
                        phase_next = (accum_base != '0) ? PH_DATA : PH_TRAILER;
                        done       = 1'b1;
                    end
                end
                else if (eph == PH_LF)
                begin
                    failed    = 1'b1;
                    fail_code = ST_SYNTAX;
                end
                else if (item.is_cr)
                begin
                    phase_next = PH_LF;
                end
                else if (item.is_semi)
                begin
                    phase_next = PH_EXT;
                end
                else if (eph == PH_EXT)
                begin
                    if (item.is_bad_ctrl)
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                end
                else if (item.is_blank)
                begin
                    phase_next = PH_CR;
                    if (({1'b0, blank_base} + 1'b1) > (BLANK_W + 1)'(BLANK_LIMIT))
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                    else
                    begin
                        blank_next = blank_base + 1'b1;
                    end
                end
                else if (eph == PH_CR)
                begin
                    failed    = 1'b1;
                    fail_code = ST_SYNTAX;
                end
                else if (!((accum_base == '0) && item.is_zero))
                begin
                    if (budget_base < BUDGET_W'(4))
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SPACE;
                    end
                    else if (!item.is_hex)
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                    else if (accum_base[ACC_W-1 -: 4] != 4'd0)
                    begin
                        failed    = 1'b1;
                        fail_code = ST_SPACE;
                    end
                    else
                    begin
                        accum_next  = {accum_base[ACC_W-5:0], item.hex_val};
                        budget_next = budget_base - BUDGET_W'(4);
                    end
                end

                if (!failed && (count_inc > {1'b0, limit_reg}))
                begin
                    done      = 1'b0;
                    failed    = 1'b1;
                    fail_code = ST_SPACE;
                end
            end
        end

        if (failed)
        begin
            status = fail_code;
            case (fail_code)
                ST_SYNTAX: phase_next = PH_ERR_SYNTAX;
                ST_SPACE:  phase_next = PH_ERR_SPACE;
                default:   phase_next = PH_ERR_GENERAL;
            endcase
        end

        res.status       = status;
        res.line_done    = done;
        res.data_follows = done && (accum_next != '0);
        res.chunk_size   = done ? accum_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            accum_reg  <= '0;
            budget_reg <= BUDGET_W'(SIZE_BITS);
            blank_reg  <= '0;
            count_reg  <= '0;
        end
        else if (item_take)
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            budget_reg <= budget_next;
            blank_reg  <= blank_next;
            count_reg  <= count_next;
        end
    end

    // result queue
    assign empty  = (ocount_reg == 2'd0);
    assign result = omem[ord_ptr_reg];

    always_comb
    begin
        ocount_next = ocount_reg + 2'(item_take) - 2'(out_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            if (item_take)
            begin
                owr_ptr_reg <= !owr_ptr_reg;
            end
            if (out_rd)
            begin
                ord_ptr_reg <= !ord_ptr_reg;
            end
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            omem[owr_ptr_reg] <= res;
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR_SYNTAX && item_take && item.command != CMD_RESTART)
        |=> phase_reg == PH_ERR_SYNTAX)
        else $error("syntax error left without restart");

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && res.line_done) |-> (res.status == ST_OK && !failed))
        else $error("line completion reported with an error");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

[src/http_chunk_size_line_parser_top.sv]
// Top level of the HTTP chunk size line parser
// A byte pushed in is held in the front queue; the parser's result for it is registered in the result queue.
// Throughput: one byte per cycle while the result queue is not full or is being popped.
// Two-entry queues sit between input, parser and output, so either side may stall.
// Reset (rst_n, asynchronous, active low): parser waits for a size line start,
// strict CRLF on, line limit 8190, both queues empty.
module http_chunk_size_line_parser_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     command,
    input  logic [7:0]                     data_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     status,
    output logic                           line_done,
    output logic                           data_follows,
    output logic [hcsp_pkg::ACC_W-1:0]     chunk_size,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hcsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcsp_pkg::LIMIT_W-1:0]   cfg_data
);
    import hcsp_pkg::*;

    logic    item_valid;
    logic    item_take;
    item_t   item;
    result_t result;

    hcsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hcsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign status       = result.status;
    assign line_done    = result.line_done;
    assign data_follows = result.data_follows;
    assign chunk_size   = result.chunk_size;

endmodule
